/* design/nwi_pkg.sv */
// ---------------------------------------------------------------------------
// nwi_pkg
// Shared types, codes and fixed-point helpers of the Newton window
// interpolator.
// ---------------------------------------------------------------------------
package nwi_pkg;

	localparam int DEG_W = 4;
	localparam logic [DEG_W-1:0] DEG_RESET = 4'd2;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FEW    = 2'd1,
		STAT_REPEAT = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_SCAN, S_WIN, S_LRD, S_LWR,
		S_DRA, S_DRB, S_DCALC, S_DDIV, S_DWR, S_DCOEF,
		S_ERC, S_ELC, S_ERX, S_ELX, S_M1, S_M2, S_M3, S_EACC,
		S_FIN
	} state_t;

	localparam logic signed [47:0] LIM48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

	typedef struct packed {
		logic signed [47:0] v;
		logic               clip;
	} sat_t;

	// clamp a 49-bit sum to 48 bits
	function automatic sat_t sat49(input logic signed [48:0] s);
		sat_t r;
		if (s[48] != s[47]) begin
			r.v = s[48] ? MIN48 : LIM48;
			r.clip = 1'b1;
		end else begin
			r.v = s[47:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

	// apply a sign to a magnitude and clamp to 48 bits
	function automatic sat_t mag_to_s48(input logic [64:0] m, input logic neg);
		sat_t r;
		if (neg) begin
			if (m[64:48] != '0 || (m[47] && m[46:0] != '0)) begin
				r.v = MIN48;
				r.clip = 1'b1;
			end else begin
				r.v = -$signed(m[47:0]);
				r.clip = 1'b0;
			end
		end else begin
			if (m[64:47] != '0) begin
				r.v = LIM48;
				r.clip = 1'b1;
			end else begin
				r.v = $signed(m[47:0]);
				r.clip = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

/* design/nwi_if.sv */
// ---------------------------------------------------------------------------
// nwi_req_if / nwi_rsp_if
// Request and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface nwi_req_if;
	import nwi_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] query_x;
	modport source(output valid, op, point_x, point_y, query_x, input ready);
	modport sink(input valid, op, point_x, point_y, query_x, output ready);
endinterface

interface nwi_rsp_if;
	import nwi_pkg::*;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [1:0]         status;
	logic               saturated;
	modport source(output valid, value, status, saturated, input ready);
	modport sink(input valid, value, status, saturated, output ready);
endinterface

/* design/newton_window_interpolator.sv */
// ---------------------------------------------------------------------------
// newton_window_interpolator
// Point table with Newton divided-difference interpolation over a window.
// ---------------------------------------------------------------------------
// Append, clear and unused codes go from idle straight to the result register.
// Query with degree n: a table scan, window growth, a load of n+1 points,
// n(n+1)/2 divisions (radix-2 restoring divider) and n(n+1)/2 products
// with accumulation, then the result register.
// One request at a time; a waiting result does not block the next request.
// Reset clears the point count and sets degree to 2; tables are not cleared.
module newton_window_interpolator #(
	parameter int TABLE_DEPTH = 64,
	parameter int MAX_DEGREE  = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [nwi_pkg::DEG_W-1:0] cfg_data,
	nwi_req_if.sink                  req,
	nwi_rsp_if.source                rsp
);
	import nwi_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = $clog2(MAX_DEGREE + 1);
	localparam int WRK_DEPTH = 2 * MAX_DEGREE + 1;
	localparam int WA = $clog2(WRK_DEPTH);
	localparam int COEF_BASE = MAX_DEGREE + 1;

	// memories
	logic [63:0] tab_mem [TABLE_DEPTH];
	logic [47:0] wrk_mem [WRK_DEPTH];
	logic [63:0] tab_rd_q;
	logic [47:0] wrk_rd_q;
	logic [AW-1:0] tab_raddr;
	logic [WA-1:0] wrk_raddr, wrk_waddr;
	logic          tab_we, wrk_we;
	logic [47:0]   wrk_wdata;

	// control state
	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [DEG_W-1:0] deg_q;
	logic res_valid_q;

	// working registers
	logic [NW-1:0] n_q, k_q, lvl_q;
	logic [NW:0]   j_q;
	logic [CW:0]   p_q;
	logic [CW-1:0] i_q;
	logic [AW-1:0] pos_q, lo_q;
	logic signed [31:0] x_q, xa_q;
	logic asc_q;
	logic signed [47:0] dy1_q, quo_q, b_q, acc_q;
	logic neg_q;
	logic [63:0] dvd_q;
	logic [32:0] dvs_q, rem_q;
	logic [5:0]  dcnt_q;
	logic [32:0] tmag_q;
	logic        tneg_q;
	logic [47:0] bmag_q;
	logic        bneg_q;
	logic [56:0] pp_lo_q, pp_hi_q;
	logic        clip_q;
	status_t     status_q;
	logic signed [31:0] res_value_q;
	logic [1:0]  res_status_q;
	logic        res_sat_q;

	// decoded helpers
	logic accept, out_free;
	logic [NW-1:0] n_calc;
	logic signed [31:0] rd_x;
	logic asc_now, scan_go;
	logic win_c1, win_c2;
	logic [NW:0] win_j1;
	logic lvl_last_k, lvl_last;
	logic signed [32:0] den;
	sat_t num_s, quo_s, prod_s, acc_s;
	logic [47:0] num_mag;
	logic [33:0] rem_sh;
	logic [80:0] prod;
	logic signed [32:0] tdiff;
	logic signed [31:0] fin_value;
	logic fin_clip;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !res_valid_q || rsp.ready;
	assign rsp.valid = res_valid_q;
	assign rsp.value = res_value_q;
	assign rsp.status = res_status_q;
	assign rsp.saturated = res_sat_q;

	assign n_calc = (32'(deg_q) > MAX_DEGREE) ? NW'(MAX_DEGREE) : NW'(deg_q);
	assign rd_x = $signed(tab_rd_q[63:32]);

	// table scan compare
	assign asc_now = (i_q == '0) ? (x_q > rd_x) : asc_q;
	assign scan_go = (i_q < count_q) && (asc_now ? (x_q >= rd_x) : (x_q < rd_x));

	// window growth step
	assign win_c1 = ((CW+1)'(pos_q) + p_q) < (CW+1)'(count_q);
	assign win_j1 = j_q + (NW+1)'(win_c1);
	assign win_c2 = (p_q <= (CW+1)'(pos_q)) && (win_j1 != (NW+1)'(n_q) + 1'b1);

	// loop ends of the difference table
	assign lvl_last_k = (32'(k_q) + 1) == (32'(n_q) - 32'(lvl_q));
	assign lvl_last   = (32'(lvl_q) + 1) == 32'(n_q);

	// divider setup
	assign den = 33'(xa_q) - 33'(rd_x);
	assign num_s = sat49(49'(dy1_q) - 49'($signed(wrk_rd_q)));
	assign num_mag = num_s.v[47] ? 48'(-num_s.v) : 48'(num_s.v);
	assign rem_sh = {rem_q, dvd_q[63]};
	assign quo_s = mag_to_s48({1'b0, dvd_q}, neg_q);

	// product assembly
	assign tdiff = 33'(x_q) - 33'(rd_x);
	assign prod = {pp_hi_q, 24'b0} + 81'(pp_lo_q);
	assign prod_s = mag_to_s48(prod[80:16], bneg_q ^ tneg_q);
	assign acc_s = sat49(49'(acc_q) + 49'(b_q));

	// final clip to 32 bits
	always_comb begin
		fin_clip = 1'b0;
		fin_value = acc_q[31:0];
		if (acc_q > 48'sh0000_7FFF_FFFF) begin
			fin_value = 32'sh7FFF_FFFF;
			fin_clip = 1'b1;
		end else if (acc_q < -48'sh0000_8000_0000) begin
			fin_value = 32'sh8000_0000;
			fin_clip = 1'b1;
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (tab_we)
			tab_mem[count_q[AW-1:0]] <= {req.point_x, req.point_y};
		tab_rd_q <= tab_mem[tab_raddr];
	end

	// difference and coefficient memory
	always_ff @(posedge clk) begin
		if (wrk_we)
			wrk_mem[wrk_waddr] <= wrk_wdata;
		wrk_rd_q <= wrk_mem[wrk_raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op_t'(req.op) == OP_QUERY && 32'(count_q) >= 32'(n_calc) + 1)
						state_d = S_SCAN;
					else
						state_d = S_FIN;
				end
			end
			S_SCAN:  if (!scan_go) state_d = S_WIN;
			S_WIN:   if (j_q == (NW+1)'(n_q) + 1'b1) state_d = S_LRD;
			S_LRD:   state_d = S_LWR;
			S_LWR: begin
				if (k_q == n_q)
					state_d = (n_q == '0) ? S_FIN : S_DRA;
				else
					state_d = S_LRD;
			end
			S_DRA:   state_d = S_DRB;
			S_DRB:   state_d = S_DCALC;
			S_DCALC: state_d = (den == '0) ? S_FIN : S_DDIV;
			S_DDIV:  if (dcnt_q == 6'd63) state_d = S_DWR;
			S_DWR, S_DCOEF: begin
				if (state_q == S_DWR && k_q == '0)
					state_d = S_DCOEF;
				else if (lvl_last_k && lvl_last)
					state_d = S_ERC;
				else
					state_d = S_DRA;
			end
			S_ERC:   state_d = S_ELC;
			S_ELC:   state_d = S_ERX;
			S_ERX:   state_d = S_ELX;
			S_ELX:   state_d = S_M1;
			S_M1:    state_d = S_M2;
			S_M2:    state_d = S_M3;
			S_M3:    state_d = (k_q == lvl_q) ? S_EACC : S_ERX;
			S_EACC:  state_d = lvl_last ? S_FIN : S_ERC;
			S_FIN:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory addressing
	always_comb begin
		tab_we    = 1'b0;
		tab_raddr = '0;
		wrk_raddr = '0;
		wrk_we    = 1'b0;
		wrk_waddr = WA'(k_q);
		wrk_wdata = quo_s.v;
		unique case (state_q)
			S_IDLE: begin
				tab_we = accept && op_t'(req.op) == OP_APPEND
					&& 32'(count_q) < TABLE_DEPTH;
			end
			S_SCAN: tab_raddr = AW'(i_q + 1'b1);
			S_LRD:  tab_raddr = AW'((CW+1)'(lo_q) + (CW+1)'(k_q));
			S_LWR: begin
				wrk_we = 1'b1;
				wrk_wdata = 48'($signed(tab_rd_q[31:0]));
			end
			S_DRA: begin
				tab_raddr = AW'((CW+1)'(lo_q) + (CW+1)'(k_q) + (CW+1)'(lvl_q) + 1'b1);
				wrk_raddr = WA'(k_q) + 1'b1;
			end
			S_DRB: begin
				tab_raddr = AW'((CW+1)'(lo_q) + (CW+1)'(k_q));
				wrk_raddr = WA'(k_q);
			end
			S_DWR:   wrk_we = 1'b1;
			S_DCOEF: begin
				wrk_we = 1'b1;
				wrk_waddr = WA'(COEF_BASE) + WA'(lvl_q);
				wrk_wdata = quo_q;
			end
			S_ERC: wrk_raddr = WA'(COEF_BASE) + WA'(lvl_q);
			S_ERX: tab_raddr = AW'((CW+1)'(lo_q) + (CW+1)'(k_q));
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			deg_q       <= DEG_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				deg_q <= cfg_data;
			if (accept && op_t'(req.op) == OP_APPEND && 32'(count_q) < TABLE_DEPTH)
				count_q <= count_q + 1'b1;
			if (accept && op_t'(req.op) == OP_CLEAR)
				count_q <= '0;
			if (state_q == S_FIN && out_free)
				res_valid_q <= 1'b1;
			else if (rsp.ready)
				res_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				acc_q    <= '0;
				clip_q   <= 1'b0;
				n_q      <= n_calc;
				x_q      <= req.query_x;
				i_q      <= '0;
				if (op_t'(req.op) == OP_APPEND && 32'(count_q) >= TABLE_DEPTH)
					status_q <= STAT_FULL;
				else if (op_t'(req.op) == OP_QUERY && 32'(count_q) < 32'(n_calc) + 1)
					status_q <= STAT_FEW;
				else
					status_q <= STAT_OK;
			end
			S_SCAN: begin
				if (i_q == '0)
					asc_q <= x_q > rd_x;
				if (scan_go) begin
					i_q <= i_q + 1'b1;
				end else begin
					pos_q <= (i_q == '0) ? '0 : AW'(i_q - 1'b1);
					lo_q  <= (i_q == '0) ? '0 : AW'(i_q - 1'b1);
					j_q   <= (NW+1)'(1);
					p_q   <= (CW+1)'(1);
				end
			end
			S_WIN: begin
				if (j_q == (NW+1)'(n_q) + 1'b1) begin
					k_q <= '0;
				end else begin
					lo_q <= lo_q - AW'(win_c2);
					j_q  <= win_j1 + (NW+1)'(win_c2);
					p_q  <= p_q + 1'b1;
				end
			end
			S_LWR: begin
				if (k_q == '0)
					acc_q <= 48'($signed(tab_rd_q[31:0]));
				if (k_q == n_q) begin
					k_q   <= '0;
					lvl_q <= '0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			S_DRB: begin
				xa_q  <= rd_x;
				dy1_q <= $signed(wrk_rd_q);
			end
			S_DCALC: begin
				if (den == '0) begin
					status_q <= STAT_REPEAT;
					clip_q   <= 1'b0;
					acc_q    <= '0;
				end else begin
					clip_q <= clip_q | num_s.clip;
					neg_q  <= num_s.v[47] ^ den[32];
					dvd_q  <= {num_mag, 16'b0};
					dvs_q  <= den[32] ? 33'(-den) : 33'(den);
					rem_q  <= '0;
					dcnt_q <= '0;
				end
			end
			// restoring division, one quotient bit a cycle
			S_DDIV: begin
				dcnt_q <= dcnt_q + 1'b1;
				if (rem_sh >= {1'b0, dvs_q}) begin
					rem_q <= 33'(rem_sh - {1'b0, dvs_q});
					dvd_q <= {dvd_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh[32:0];
					dvd_q <= {dvd_q[62:0], 1'b0};
				end
			end
			S_DWR, S_DCOEF: begin
				if (state_q == S_DWR) begin
					quo_q  <= quo_s.v;
					clip_q <= clip_q | quo_s.clip;
				end
				if (!(state_q == S_DWR && k_q == '0)) begin
					if (lvl_last_k) begin
						k_q   <= '0;
						lvl_q <= lvl_last ? '0 : lvl_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
			end
			S_ELC: begin
				b_q <= $signed(wrk_rd_q);
				k_q <= '0;
			end
			S_ELX: begin
				tmag_q <= tdiff[32] ? 33'(-tdiff) : 33'(tdiff);
				tneg_q <= tdiff[32];
				bmag_q <= b_q[47] ? 48'(-b_q) : 48'(b_q);
				bneg_q <= b_q[47];
			end
			S_M1: pp_lo_q <= 57'(bmag_q[23:0]) * 57'(tmag_q);
			S_M2: pp_hi_q <= 57'(bmag_q[47:24]) * 57'(tmag_q);
			S_M3: begin
				b_q    <= prod_s.v;
				clip_q <= clip_q | prod_s.clip;
				k_q    <= k_q + 1'b1;
			end
			S_EACC: begin
				acc_q  <= acc_s.v;
				clip_q <= clip_q | acc_s.clip;
				lvl_q  <= lvl_q + 1'b1;
			end
			S_FIN: begin
				if (out_free) begin
					res_value_q  <= fin_value;
					res_status_q <= status_q;
					res_sat_q    <= clip_q | fin_clip;
				end
			end
			default: ;
		endcase
	end

	// point count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= TABLE_DEPTH)
		else $error("point count beyond table depth");

	// a clear request empties the table
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_t'(req.op) == OP_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty table");

	// a repeated-x result never reports saturation
	a_repeat_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free && status_q == STAT_REPEAT)
		|=> (res_valid_q && !res_sat_q && res_value_q == '0))
		else $error("repeated-x result carries value or saturation");

endmodule
